// ===== hw/rtl/substring_find_and_count_assert.svh =====
// ----------------------------------------------------------------------------
// substring_find_and_count assertion macros
// Shared concurrent assertion forms, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_FIND_AND_COUNT_ASSERT_SVH
`define SUBSTRING_FIND_AND_COUNT_ASSERT_SVH

// same-cycle implication
`define SFC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

// next-cycle implication
`define SFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`endif

// ===== hw/rtl/sfc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfc_pkg
// Types and fixed constants of the substring find and count block.
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam int unsigned WIN_DEPTH  = 8;
    localparam int unsigned LEN_W      = 4;
    localparam int unsigned CNT_W      = 16;
    localparam int unsigned NEEDLE_W   = 8 * WIN_DEPTH;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_MODE = 2'd2;

    typedef struct packed {
        logic [7:0] haystack_byte;
        logic       has_byte;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        logic [CNT_W-1:0] match_count;
        logic [CNT_W-1:0] first_index;
        logic             found;
        logic             overflow;
    } t_out_beat;

    // one byte's match event toward the hit tally
    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] start;
        logic [CNT_W-1:0] stop;
        logic             close;
    } t_hit_evt;

    // tally values including the current beat
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] first;
        logic             seen;
    } t_hit_sum;

endpackage

// ===== hw/rtl/sfc_stream_if.sv =====
// ----------------------------------------------------------------------------
// sfc_stream_if
// Valid/ready stream channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface sfc_stream_if #(parameter type t_payload = logic);

    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ===== hw/rtl/sfc_cell.sv =====
// ----------------------------------------------------------------------------
// sfc_cell
// One window byte: shifts from its neighbor and compares against its
// needle byte.
// ----------------------------------------------------------------------------
module sfc_cell #(
    parameter int unsigned POS = 0
) (
    input  logic                           i_clk,
    input  logic                           i_shift,
    input  logic [7:0]                     i_byte,
    input  logic [sfc_pkg::NEEDLE_W-1:0]   i_needle,
    input  logic [sfc_pkg::LEN_W-1:0]      i_len,
    output logic [7:0]                     o_byte,
    output logic                           o_eq
);

    logic [7:0] r_byte;
    logic       active;
    logic [2:0] sel;

    // cell at distance POS from the newest byte pairs with needle byte len-1-POS
    assign active = POS < 32'(i_len);
    assign sel    = 3'(i_len - 4'(POS) - 4'd1);
    assign o_eq   = !active || (i_byte == i_needle[8*sel +: 8]);
    assign o_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

endmodule

// ===== hw/rtl/sfc_tally.sv =====
// ----------------------------------------------------------------------------
// sfc_tally
// Match counter, first-hit capture and greedy non-overlap bookkeeping.
// ----------------------------------------------------------------------------
`include "substring_find_and_count_assert.svh"

module sfc_tally (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_overlap,
    input  sfc_pkg::t_hit_evt i_evt,
    output sfc_pkg::t_hit_sum o_sum
);

    localparam logic [sfc_pkg::CNT_W-1:0] CNT_MAX = '1;

    logic [sfc_pkg::CNT_W-1:0] r_count, n_count;
    logic [sfc_pkg::CNT_W-1:0] r_first, n_first;
    logic [sfc_pkg::CNT_W-1:0] r_next,  n_next;
    logic                      r_seen,  n_seen;
    logic                      counted;

    always_comb begin
        counted = i_evt.hit && (i_overlap || (i_evt.start >= r_next));
        n_seen  = r_seen || i_evt.hit;
        n_first = (i_evt.hit && !r_seen) ? i_evt.start : r_first;
        n_count = (counted && (r_count != CNT_MAX)) ? r_count + 1'b1 : r_count;
        n_next  = counted ? i_evt.stop : r_next;
    end

    assign o_sum.count = n_count;
    assign o_sum.first = n_first;
    assign o_sum.seen  = n_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_evt.close) begin
            r_count <= '0;
            r_first <= '0;
            r_next  <= '0;
            r_seen  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_first <= n_first;
            r_next  <= n_next;
            r_seen  <= n_seen;
        end
    end

    `SFC_ASSERT_IMPLY(a_count_needs_seen, i_clk, i_rst_n, r_count != '0, r_seen)
    `SFC_ASSERT_IMPLY(a_next_needs_seen, i_clk, i_rst_n, !r_seen, r_next == '0)
    `SFC_ASSERT_NEXT(a_count_monotonic, i_clk, i_rst_n, !i_evt.close,
                     r_count >= $past(r_count))

endmodule

// ===== hw/rtl/substring_find_and_count.sv =====
// ----------------------------------------------------------------------------
// substring_find_and_count
// Streams haystack bytes through a chain of compare cells and counts needle
// occurrences, reporting count, first index and status at end of stream.
// ----------------------------------------------------------------------------
// Usage:
//   i_hay carries one haystack beat (byte, has_byte, last). A beat with
//   has_byte low takes no byte; a beat with last high closes the stream.
//   o_res carries one result beat per closed stream.
//   Throughput is one beat per cycle, except that a beat with last stalls
//   while the output register is full: every cell compares its byte in the
//   same cycle the byte shifts in, and the tally updates in that cycle too.
//   The result beat comes from the output register in the cycle after the last beat.
//   While a result waits on o_res, beats without last keep being accepted;
//   a beat with last waits until the output register frees up.
//   Needle, length and overlap mode are written through the i_cfg_* port;
//   a write is registered and applies from the next byte.
//   Reset clears the stream counters, the result valid flag and the
//   configuration (overlap mode on, empty needle). No clearing pass is run.
// ----------------------------------------------------------------------------
`include "substring_find_and_count_assert.svh"

module substring_find_and_count #(
    parameter int unsigned      MAX_NEEDLE = 8,
    parameter longint unsigned  MAX_LENGTH = 65535
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sfc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sfc_pkg::NEEDLE_W-1:0]       i_cfg_wdata,
    sfc_stream_if.sink                         i_hay,
    sfc_stream_if.source                       o_res
);

    localparam int unsigned CAP =
        (MAX_NEEDLE < sfc_pkg::WIN_DEPTH) ? MAX_NEEDLE : sfc_pkg::WIN_DEPTH;
    localparam logic [sfc_pkg::CNT_W-1:0] LEN_LIMIT =
        (MAX_LENGTH < 64'd65535) ? sfc_pkg::CNT_W'(MAX_LENGTH) : '1;

    // configuration
    logic [sfc_pkg::NEEDLE_W-1:0] r_needle;
    logic [sfc_pkg::LEN_W-1:0]    r_needle_len;
    logic                         r_overlap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle     <= '0;
            r_needle_len <= '0;
            r_overlap    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sfc_pkg::CFG_NEEDLE_BYTES: r_needle     <= i_cfg_wdata;
                sfc_pkg::CFG_NEEDLE_LEN:   r_needle_len <= i_cfg_wdata[sfc_pkg::LEN_W-1:0];
                sfc_pkg::CFG_OVERLAP_MODE: r_overlap    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic [sfc_pkg::LEN_W-1:0] len_cap;
    assign len_cap = (r_needle_len > sfc_pkg::LEN_W'(CAP)) ? sfc_pkg::LEN_W'(CAP)
                                                           : r_needle_len;

    // input handshake
    sfc_pkg::t_in_beat in_beat;
    logic              r_out_valid;
    logic              acc, room, take, drop, close;

    assign in_beat     = i_hay.payload;
    assign i_hay.ready = !r_out_valid || o_res.ready || !in_beat.last;
    assign acc         = i_hay.valid && i_hay.ready;

    logic [sfc_pkg::CNT_W-1:0] r_byte_count, n_byte_count, idx_p1;
    logic                      r_overflow, n_overflow;

    assign room   = r_byte_count < LEN_LIMIT;
    assign take   = acc && in_beat.has_byte && room;
    assign drop   = acc && in_beat.has_byte && !room;
    assign close  = acc && in_beat.last;
    assign idx_p1 = r_byte_count + 1'b1;

    // compare chain, cell 0 holds the newest byte
    logic [7:0]     w_byte [CAP];
    logic [CAP-1:0] w_eq;

    for (genvar k = 0; k < CAP; k++) begin : g_cell
        logic [7:0] cell_in;
        if (k == 0) begin : g_head
            assign cell_in = in_beat.haystack_byte;
        end else begin : g_link
            assign cell_in = w_byte[k-1];
        end
        sfc_cell #(.POS(k)) u_cell (
            .i_clk    (i_clk),
            .i_shift  (take),
            .i_byte   (cell_in),
            .i_needle (r_needle),
            .i_len    (len_cap),
            .o_byte   (w_byte[k]),
            .o_eq     (w_eq[k])
        );
    end

    sfc_pkg::t_hit_evt evt;
    sfc_pkg::t_hit_sum sum;

    always_comb begin
        evt.hit   = take && (len_cap != '0) &&
                    (idx_p1 >= sfc_pkg::CNT_W'(len_cap)) && (&w_eq);
        evt.start = idx_p1 - sfc_pkg::CNT_W'(len_cap);
        evt.stop  = idx_p1;
        evt.close = close;
    end

    sfc_tally u_tally (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_overlap (r_overlap),
        .i_evt     (evt),
        .o_sum     (sum)
    );

    // stream length and overflow
    always_comb begin
        n_byte_count = take ? idx_p1 : r_byte_count;
        n_overflow   = r_overflow || drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || close) begin
            r_byte_count <= '0;
            r_overflow   <= 1'b0;
        end else begin
            r_byte_count <= n_byte_count;
            r_overflow   <= n_overflow;
        end
    end

    // result register
    sfc_pkg::t_out_beat r_res, n_res;

    always_comb begin
        if (len_cap == '0) begin
            n_res.match_count = '0;
            n_res.first_index = '0;
            n_res.found       = 1'b1;
        end else begin
            n_res.match_count = sum.count;
            n_res.first_index = sum.seen ? sum.first : n_byte_count;
            n_res.found       = sum.seen;
        end
        n_res.overflow = n_overflow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (close) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (close) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_res;

    `SFC_ASSERT_IMPLY(a_count_in_limit, i_clk, i_rst_n, 1'b1, r_byte_count <= LEN_LIMIT)
    `SFC_ASSERT_IMPLY(a_overflow_at_limit, i_clk, i_rst_n, r_overflow,
                      r_byte_count == LEN_LIMIT)
    `SFC_ASSERT_NEXT(a_close_clears, i_clk, i_rst_n, close,
                     (r_byte_count == '0) && !r_overflow && r_out_valid)

endmodule
